FILE: sv/linear_probe_hash_table_unit_macros.svh
// ----------------------------------------------------------------------------
// Linear probe hash table - assertion macros
// Shared concurrent assertion forms for the hash table unit.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define LPHT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/lpht_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe hash table - package
// Operation, result and slot codes plus fixed field widths.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int KEY_W       = 64;
    localparam int VAL_W       = 64;
    localparam int SIZE_W      = 8;
    localparam int SLOT_OUT_W  = 7;
    localparam int SUM_W       = 11;   // eight bytes of up to 255
    localparam int DEFAULT_TABLE_SIZE = 101;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_UPDATE = 2'd2,
        OP_DELETE = 2'd3
    } op_kind_t;

    typedef enum logic [1:0] {
        RES_DONE      = 2'd0,
        RES_NOT_FOUND = 2'd1,
        RES_FULL      = 2'd2
    } res_status_t;

    typedef enum logic [1:0] {
        SLOT_EMPTY = 2'd0,
        SLOT_USED  = 2'd1,
        SLOT_TOMB  = 2'd2
    } slot_state_t;

endpackage

FILE: sv/linear_probe_hash_table_unit.sv
// ----------------------------------------------------------------------------
// Linear probe hash table unit
// Open-addressed key/value store with linear probing and tombstone delete.
// ----------------------------------------------------------------------------
// One item is one operation (insert, lookup, update value, delete) on a
// 64-bit key. The key is cut at its first zero byte or after KEY_BYTES
// bytes; its home slot is the byte sum modulo table_size, found by a shared
// subtract-and-compare unit over SUM_W (11) restoring steps. The same unit
// then wraps the probe pointer while the probe reads one slot per cycle
// from the slot memories, probing 1 to table_size slots per item. The
// result is offered and tready returns in the same cycle. A result still
// waiting at the output holds the probe on its last slot until it is taken.
// Insert takes the first empty or tombstone slot and does not look for
// duplicates; lookup, update and delete skip tombstones and stop at an
// empty slot. After reset and after every table_size write the store runs
// a clearing pass over all MAX_SLOTS slots during which no item is taken.
// A table_size of 0 acts as 1, and values above MAX_SLOTS act as MAX_SLOTS.
module linear_probe_hash_table_unit
    import lpht_pkg::*;
#(
    parameter int MAX_SLOTS = 128,
    parameter int KEY_BYTES = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    // configuration: table_size
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,
    // operation items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // [63:0] key_word, [127:64] value_word
    input  logic [1:0]   s_axis_tuser,  // [1:0] kind
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,  // [63:0] found_value, [70:64] slot_index,
                                        // [78:71] entry_count, [79] zero
    output logic [1:0]   m_axis_tuser   // [1:0] status
);

`include "linear_probe_hash_table_unit_macros.svh"

    localparam int IDX_W = $clog2(MAX_SLOTS);
    localparam int DIV_W = $clog2(SUM_W);
    localparam logic [SIZE_W-1:0] MAX8 =
        (MAX_SLOTS < 256) ? SIZE_W'(MAX_SLOTS) : {SIZE_W{1'b1}};
    localparam logic [SIZE_W-1:0] RESET_SIZE =
        (MAX_SLOTS < DEFAULT_TABLE_SIZE) ? SIZE_W'(MAX_SLOTS) : SIZE_W'(DEFAULT_TABLE_SIZE);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t              state_reg,     state_next;
    logic [SIZE_W-1:0]   size_reg,      size_next;
    logic [SIZE_W-1:0]   count_reg,     count_next;
    logic [IDX_W-1:0]    clr_reg,       clr_next;
    op_kind_t            kind_reg,      kind_next;
    logic [KEY_W-1:0]    key_reg,       key_next;
    logic [VAL_W-1:0]    val_reg,       val_next;
    logic [SUM_W-1:0]    sum_reg,       sum_next;
    logic [DIV_W-1:0]    div_reg,       div_next;
    logic [SIZE_W-1:0]   pos_reg,       pos_next;
    logic [SIZE_W-1:0]   step_reg,      step_next;
    logic                out_valid_reg, out_valid_next;
    res_status_t         out_status_reg, out_status_next;
    logic [VAL_W-1:0]    out_value_reg, out_value_next;
    logic [SLOT_OUT_W-1:0] out_slot_reg, out_slot_next;
    logic [SIZE_W-1:0]   out_count_reg, out_count_next;

    // ------------------------------------------------------------------
    // Slot memories (registered read, one port each way)
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]    key_mem  [MAX_SLOTS];
    logic [VAL_W-1:0]    val_mem  [MAX_SLOTS];
    slot_state_t         stat_mem [MAX_SLOTS];
    logic [KEY_W-1:0]    key_rd_reg;
    logic [VAL_W-1:0]    val_rd_reg;
    slot_state_t         stat_rd_reg;

    logic [IDX_W-1:0]    rd_addr;
    logic [IDX_W-1:0]    wr_addr;
    logic                key_we;
    logic                val_we;
    logic                stat_we;
    slot_state_t         stat_wdata;

    // ------------------------------------------------------------------
    // Key canonical form and byte sum, taken at acceptance
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]    canon_key;
    logic [SUM_W-1:0]    canon_sum;

    always_comb
    begin
        logic alive;
        logic [7:0] kbyte;
        alive     = 1'b1;
        canon_key = '0;
        canon_sum = '0;
        for (int b = 0; b < 8; b++)
        begin
            kbyte = s_axis_tdata[8*b +: 8];
            if (b >= KEY_BYTES || kbyte == 8'd0)
            begin
                alive = 1'b0;
            end
            if (alive)
            begin
                canon_key[8*b +: 8] = kbyte;
                canon_sum = canon_sum + SUM_W'(kbyte);
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared subtract-and-compare unit: operand minus live table size.
    // Hash phase: one restoring division step. Probe phase: pointer wrap.
    // ------------------------------------------------------------------
    logic [SIZE_W:0]     sub_a;
    logic [SIZE_W+1:0]   sub_diff;
    logic                sub_ge;

    assign sub_a = (state_reg == S_HASH) ? {pos_reg, sum_reg[SUM_W-1]}
                                         : ({1'b0, pos_reg} + (SIZE_W+1)'(1));
    assign sub_diff = {1'b0, sub_a} - {2'b00, size_reg};
    assign sub_ge   = !sub_diff[SIZE_W+1];

    logic [SIZE_W-1:0]   rem_new;
    logic [SIZE_W-1:0]   pos_wrap;

    assign rem_new  = sub_ge ? sub_diff[SIZE_W-1:0] : sub_a[SIZE_W-1:0];
    assign pos_wrap = sub_ge ? '0 : sub_a[SIZE_W-1:0];

    // ------------------------------------------------------------------
    // Probe decision on the slot read back for pos_reg
    // ------------------------------------------------------------------
    logic key_match;
    logic probe_hit;
    logic probe_stop;
    logic probe_last;
    logic probe_end;
    logic out_free;

    assign key_match  = (key_rd_reg == key_reg);
    assign probe_hit  = (kind_reg == OP_INSERT) ? (stat_rd_reg != SLOT_USED)
                                                : (stat_rd_reg == SLOT_USED && key_match);
    assign probe_stop = (kind_reg != OP_INSERT) && (stat_rd_reg == SLOT_EMPTY);
    assign probe_last = (step_reg == size_reg - SIZE_W'(1));
    assign probe_end  = probe_hit || probe_stop || probe_last;
    assign out_free   = !out_valid_reg || m_axis_tready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        size_next       = size_reg;
        count_next      = count_reg;
        clr_next        = clr_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        val_next        = val_reg;
        sum_next        = sum_reg;
        div_next        = div_reg;
        pos_next        = pos_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_slot_next   = out_slot_reg;
        out_count_next  = out_count_reg;

        rd_addr    = IDX_W'(pos_reg);
        wr_addr    = IDX_W'(pos_reg);
        key_we     = 1'b0;
        val_we     = 1'b0;
        stat_we    = 1'b0;
        stat_wdata = SLOT_EMPTY;

        // drop the result once taken
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                // sweep every slot back to empty
                wr_addr = clr_reg;
                stat_we = 1'b1;
                clr_next = clr_reg + IDX_W'(1);
                if (clr_reg == IDX_W'(MAX_SLOTS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    kind_next  = op_kind_t'(s_axis_tuser);
                    key_next   = canon_key;
                    val_next   = s_axis_tdata[127:64];
                    sum_next   = canon_sum;
                    div_next   = DIV_W'(SUM_W - 1);
                    pos_next   = '0;
                    state_next = S_HASH;
                end
            end

            S_HASH:
            begin
                // one remainder bit per cycle, MSB of the sum first
                pos_next = rem_new;
                sum_next = sum_reg << 1;
                div_next = div_reg - DIV_W'(1);
                if (div_reg == '0)
                begin
                    rd_addr    = IDX_W'(rem_new);
                    step_next  = '0;
                    state_next = S_PROBE;
                end
            end

            S_PROBE:
            begin
                if (!probe_end)
                begin
                    // advance to the next slot, wrapping at the table size
                    pos_next  = pos_wrap;
                    step_next = step_reg + SIZE_W'(1);
                    rd_addr   = IDX_W'(pos_wrap);
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = '0;
                    out_slot_next   = '0;
                    out_count_next  = count_reg;
                    out_status_next = (kind_reg == OP_INSERT) ? RES_FULL : RES_NOT_FOUND;
                    if (probe_hit)
                    begin
                        out_status_next = RES_DONE;
                        out_slot_next   = SLOT_OUT_W'(pos_reg);
                        case (kind_reg)
                            OP_INSERT:
                            begin
                                key_we         = 1'b1;
                                val_we         = 1'b1;
                                stat_we        = 1'b1;
                                stat_wdata     = SLOT_USED;
                                count_next     = count_reg + SIZE_W'(1);
                                out_count_next = count_reg + SIZE_W'(1);
                            end
                            OP_LOOKUP:
                            begin
                                out_value_next = val_rd_reg;
                            end
                            OP_UPDATE:
                            begin
                                val_we = 1'b1;
                            end
                            default:
                            begin
                                stat_we        = 1'b1;
                                stat_wdata     = SLOT_TOMB;
                                count_next     = count_reg - SIZE_W'(1);
                                out_count_next = count_reg - SIZE_W'(1);
                            end
                        endcase
                    end
                    state_next = S_IDLE;
                end
                // else hold: result register still full, read keeps pos_reg
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // table_size write: take the clamped size and empty the store
        if (cfg_wr_en)
        begin
            if (cfg_wr_data == 8'd0)
            begin
                size_next = SIZE_W'(1);
            end
            else if (cfg_wr_data > MAX8)
            begin
                size_next = MAX8;
            end
            else
            begin
                size_next = cfg_wr_data;
            end
            count_next = '0;
            clr_next   = '0;
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            size_reg       <= RESET_SIZE;
            count_reg      <= '0;
            clr_reg        <= '0;
            div_reg        <= '0;
            pos_reg        <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
            kind_reg       <= OP_INSERT;
            out_status_reg <= RES_DONE;
        end
        else
        begin
            state_reg      <= state_next;
            size_reg       <= size_next;
            count_reg      <= count_next;
            clr_reg        <= clr_next;
            div_reg        <= div_next;
            pos_reg        <= pos_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
            kind_reg       <= kind_next;
            out_status_reg <= out_status_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        val_reg       <= val_next;
        sum_reg       <= sum_next;
        out_value_reg <= out_value_next;
        out_slot_reg  <= out_slot_next;
        out_count_reg <= out_count_next;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
        begin
            key_mem[wr_addr] <= key_reg;
        end
        key_rd_reg <= key_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[wr_addr] <= val_reg;
        end
        val_rd_reg <= val_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[wr_addr] <= stat_wdata;
        end
        stat_rd_reg <= stat_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {1'b0, out_count_reg, out_slot_reg, out_value_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `LPHT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
        s_axis_tvalid && s_axis_tready && !cfg_wr_en,
        state_reg == S_HASH && !s_axis_tready,
        "item accepted but sequencer not hashing")
    `LPHT_ASSERT_NOW(a_count_in_size, clk, rst_n, 1'b1, count_reg <= size_reg,
        "occupied count exceeds table size")
    `LPHT_ASSERT_NOW(a_pos_in_size, clk, rst_n,
        state_reg == S_HASH || state_reg == S_PROBE, pos_reg < size_reg,
        "probe pointer or remainder outside table")
    `LPHT_ASSERT_NOW(a_step_in_size, clk, rst_n, state_reg == S_PROBE,
        step_reg < size_reg, "probe ran past table size")
    `LPHT_ASSERT_NOW(a_fail_fields_zero, clk, rst_n,
        out_valid_reg && out_status_reg != RES_DONE,
        out_slot_reg == '0 && out_value_reg == '0,
        "failed result carries slot or value")

endmodule
